@@ hdl/mqm_pkg.sv @@
package mqm_pkg;

   // Default sizing of the mailbox
   localparam int DEF_MESSAGES      = 16;
   localparam int DEF_MESSAGE_BYTES = 32;

   // Fixed widths of the item fields
   localparam int WORD_BITS  = 64;
   localparam int DATA_BITS  = 4 * WORD_BITS;
   localparam int DATA_BYTES = DATA_BITS / 8;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // Item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // Result status codes
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_FULL     = 3'd1;
   localparam logic [2:0] STATUS_TOO_LONG = 3'd2;
   localparam logic [2:0] STATUS_EMPTY    = 3'd3;
   localparam logic [2:0] STATUS_ENDED    = 3'd4;

   typedef struct packed {
      logic                 kind;
      logic [7:0]           request_length;
      logic [7:0]           read_offset;
      logic [WORD_BITS-1:0] in_word0;
      logic [WORD_BITS-1:0] in_word1;
      logic [WORD_BITS-1:0] in_word2;
      logic [WORD_BITS-1:0] in_word3;
   } req_item_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [5:0]           byte_count;
      logic [WORD_BITS-1:0] out_word0;
      logic [WORD_BITS-1:0] out_word1;
      logic [WORD_BITS-1:0] out_word2;
      logic [WORD_BITS-1:0] out_word3;
   } rsp_item_type;

   // Classified command passed from front to back
   typedef struct packed {
      logic                 kind;
      logic                 too_long;
      logic [7:0]           length;
      logic [7:0]           offset;
      logic [DATA_BITS-1:0] data;
   } cmd_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_READ
   } back_state_type;

endpackage

@@ hdl/mqm_front.sv @@
module mqm_front #(
   parameter int MESSAGE_BYTES = mqm_pkg::DEF_MESSAGE_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mqm_pkg::req_item_type req_item,
   output logic                  cmd_valid,
   input  logic                  cmd_take,
   output mqm_pkg::cmd_type      cmd
);
   import mqm_pkg::*;

   cmd_type                q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   cmd_type                classified;
   logic                   push;
   logic                   pop;

   // Classify the incoming item
   always_comb begin
      classified.kind     = req_item.kind;
      classified.too_long = (req_item.request_length >= 8'(MESSAGE_BYTES));
      classified.length   = req_item.request_length;
      classified.offset   = req_item.read_offset;
      classified.data     = {req_item.in_word3, req_item.in_word2,
                             req_item.in_word1, req_item.in_word0};
   end

   assign req_stall = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_take && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   // Advance queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified item
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= classified;
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("command queue over capacity");

endmodule

@@ hdl/mqm_back.sv @@
module mqm_back #(
   parameter int MESSAGES      = mqm_pkg::DEF_MESSAGES,
   parameter int MESSAGE_BYTES = mqm_pkg::DEF_MESSAGE_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_take,
   input  mqm_pkg::cmd_type      cmd,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mqm_pkg::rsp_item_type rsp_item
);
   import mqm_pkg::*;

   localparam int SLOT_W   = $clog2(MESSAGES);
   localparam int CNT_W    = $clog2(MESSAGES + 1);
   localparam int SUM_W    = SLOT_W + 1;
   localparam int LEN_W    = $clog2(MESSAGE_BYTES);
   localparam int ROW_BITS = MESSAGE_BYTES * 8;

   // Message rows and their lengths
   logic [ROW_BITS-1:0] mem_ff     [MESSAGES];
   logic [LEN_W-1:0]    len_mem_ff [MESSAGES];

   back_state_type      state_ff, state_in;
   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]    held_ff, held_in;
   logic [ROW_BITS-1:0] rd_row_ff;
   logic [LEN_W-1:0]    rd_len_ff;
   logic [7:0]          off_ff, off_in;
   logic [7:0]          want_ff, want_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_item_ff, rsp_item_in;

   logic                out_free;
   logic                full;
   logic                empty;
   logic                mem_we;
   logic                rd_en;
   logic [SUM_W-1:0]    tail_sum;
   logic [SLOT_W-1:0]   tail;
   logic [SLOT_W-1:0]   head_next;
   logic                past_end;
   logic [LEN_W-1:0]    avail;
   logic [LEN_W-1:0]    take;
   logic [DATA_BITS-1:0] shifted;
   logic [DATA_BITS-1:0] masked;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = (held_ff == CNT_W'(MESSAGES));
   assign empty     = (held_ff == '0);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Locate the tail slot and the slot after the head
   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(held_ff);
      if (tail_sum >= SUM_W'(MESSAGES)) begin
         tail = SLOT_W'(tail_sum - SUM_W'(MESSAGES));
      end else begin
         tail = SLOT_W'(tail_sum);
      end
      head_next = (head_ff == SLOT_W'(MESSAGES - 1)) ? '0 : head_ff + 1'b1;
   end

   // Cut the requested window out of the head row
   always_comb begin
      past_end = (off_ff >= 8'(rd_len_ff));
      avail    = rd_len_ff - off_ff[LEN_W-1:0];
      take     = (want_ff < 8'(avail)) ? want_ff[LEN_W-1:0] : avail;
      shifted  = DATA_BITS'(rd_row_ff) >> {off_ff[LEN_W-1:0], 3'b000};
      for (int b = 0; b < DATA_BYTES; b++) begin
         masked[b*8 +: 8] = (6'(b) < 6'(take)) ? shifted[b*8 +: 8] : 8'h00;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid && out_free && (cmd.kind == KIND_READ) && !empty) begin
               state_in = BACK_READ;
            end
         end
         BACK_READ: begin
            if (out_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // Outputs and state updates
   always_comb begin
      cmd_take     = 1'b0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      head_in      = head_ff;
      held_in      = held_ff;
      off_in       = off_ff;
      want_in      = want_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_take    = 1'b1;
               rsp_item_in = '0;
               if (cmd.kind == KIND_WRITE) begin
                  rsp_valid_in = 1'b1;
                  if (full) begin
                     rsp_item_in.status = STATUS_FULL;
                  end else if (cmd.too_long) begin
                     rsp_item_in.status = STATUS_TOO_LONG;
                  end else begin
                     mem_we                 = 1'b1;
                     held_in                = held_ff + 1'b1;
                     rsp_item_in.status     = STATUS_OK;
                     rsp_item_in.byte_count = 6'(cmd.length);
                  end
               end else if (empty) begin
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.status = STATUS_EMPTY;
               end else begin
                  rd_en   = 1'b1;
                  off_in  = cmd.offset;
                  want_in = cmd.length;
               end
            end
         end
         BACK_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '0;
               if (past_end) begin
                  head_in            = head_next;
                  held_in            = held_ff - 1'b1;
                  rsp_item_in.status = STATUS_ENDED;
               end else begin
                  rsp_item_in.status     = STATUS_OK;
                  rsp_item_in.byte_count = 6'(take);
                  rsp_item_in.out_word0  = masked[0*WORD_BITS +: WORD_BITS];
                  rsp_item_in.out_word1  = masked[1*WORD_BITS +: WORD_BITS];
                  rsp_item_in.out_word2  = masked[2*WORD_BITS +: WORD_BITS];
                  rsp_item_in.out_word3  = masked[3*WORD_BITS +: WORD_BITS];
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         head_ff      <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload and request fields
   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      off_ff      <= off_in;
      want_ff     <= want_in;
   end

   // Write the tail row, read the head row
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[tail]     <= cmd.data[ROW_BITS-1:0];
         len_mem_ff[tail] <= LEN_W'(cmd.length);
      end
      if (rd_en) begin
         rd_row_ff <= mem_ff[head_ff];
         rd_len_ff <= len_mem_ff[head_ff];
      end
   end

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(MESSAGES))
      else $error("held count above capacity");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !full)
      else $error("store written while full");

   a_read_has_message: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_READ) |-> (held_ff != '0))
      else $error("read pending with empty queue");

   a_read_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == BACK_READ) |-> $past(rd_en))
      else $error("read state entered without row fetch");

endmodule

@@ hdl/message_queue_mailbox_unit.sv @@
// Results: a write result is registered after the item leaves the command queue;
// a read of a stored message also fetches the head row into a register first.
// Throughput: one write per cycle unless the output stalls; the back end takes no
// item during a read; a 2-entry queue decouples intake from execution.
// Reset: synchronous, active high; clears queue, head slot and message count.
// Store contents are not cleared and no clearing pass is run.
module message_queue_mailbox_unit #(
   parameter int MESSAGES      = mqm_pkg::DEF_MESSAGES,
   parameter int MESSAGE_BYTES = mqm_pkg::DEF_MESSAGE_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mqm_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mqm_pkg::rsp_item_type rsp_item
);
   import mqm_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_take;

   // Accept and classify items
   mqm_front #(
      .MESSAGE_BYTES(MESSAGE_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .cmd_valid(cmd_valid),
      .cmd_take (cmd_take),
      .cmd      (cmd)
   );

   // Execute against the message store
   mqm_back #(
      .MESSAGES     (MESSAGES),
      .MESSAGE_BYTES(MESSAGE_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(cmd_valid),
      .cmd_take (cmd_take),
      .cmd      (cmd),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

endmodule
